/* src/slotpg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package slotpg_pkg;

    // Field widths fixed by the port definition
    localparam int LEN_W = 12;
    localparam int IDX_W = 4;
    localparam int OFS_W = 12;
    localparam int CFG_W = 12;

    // Depth of the queues between the parts
    localparam int QUEUE_DEPTH = 2;

    // Reset value of the record area start
    localparam logic [CFG_W-1:0] DATA_START_RST = 12'd96;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_DEL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK
    } t_state;

    // Classified request, front to back
    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] idx;
        logic             idx_ok;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic             accepted;
        logic [IDX_W-1:0] granted_slot;
        logic [OFS_W-1:0] record_offset;
    } t_result;

endpackage
`default_nettype wire

/* src/slotpg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module slotpg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/slotpg_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module slotpg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* src/slotpg_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module slotpg_front #(
    parameter int SLOT_COUNT = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    output logic                         o_full,
    input  wire                          i_kind,
    input  wire  [slotpg_pkg::LEN_W-1:0] i_record_length,
    input  wire  [slotpg_pkg::IDX_W-1:0] i_slot_index,
    input  wire                          i_pop,
    output slotpg_pkg::t_cmd             o_cmd,
    output logic                         o_empty
);
    import slotpg_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int IW = ((SW > IDX_W) ? SW : IDX_W) + 1;

    t_cmd                    w_cmd;
    logic [$bits(t_cmd)-1:0] w_rdata;

    // Classify the request and range-check the delete index
    always_comb begin
        w_cmd.op     = t_op'(i_kind);
        w_cmd.len    = i_record_length;
        w_cmd.idx    = i_slot_index;
        w_cmd.idx_ok = (IW'(i_slot_index) < IW'(SLOT_COUNT));
    end

    slotpg_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (w_rdata),
        .o_empty (o_empty)
    );

    assign o_cmd = t_cmd'(w_rdata);

endmodule
`default_nettype wire

/* src/slotpg_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module slotpg_back #(
    parameter int PAGE_BYTES = 4096,
    parameter int SLOT_COUNT = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  slotpg_pkg::t_cmd       i_cmd,
    input  wire                          i_cmd_empty,
    output logic                         o_cmd_pop,
    input  wire  [slotpg_pkg::CFG_W-1:0] i_data_start,
    input  wire                          i_res_full,
    output logic                         o_res_push,
    output slotpg_pkg::t_result          o_res
);
    import slotpg_pkg::*;

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int OW    = (OFF_W > LEN_W) ? OFF_W : LEN_W;
    localparam int IW    = ((SW > IDX_W) ? SW : IDX_W) + 1;

    typedef struct packed {
        logic [OW-1:0]    off;
        logic [LEN_W-1:0] size;
    } t_entry;

    t_state                  r_state;
    t_state                  n_state;
    logic [SW-1:0]           r_scan;
    logic [SLOT_COUNT-1:0]   r_busy;
    logic [SLOT_COUNT-1:0]   r_placed;
    logic [LEN_W-1:0]        r_len;
    logic [OW-1:0]           r_off;
    logic [SW-1:0]           r_slot;
    logic                    r_was_placed;
    logic [OW-1:0]           r_prev_end;

    logic [$bits(t_entry)-1:0] w_rdata_raw;
    t_entry                  w_rdata;
    t_entry                  w_wdata;
    logic                    w_we;
    logic [SW-1:0]           w_raddr;
    logic                    w_fit;
    logic                    w_last;
    logic [OW-1:0]           w_sel_off;
    logic [OW:0]             w_sum;
    logic                    w_overflow;
    logic [IW-1:0]           w_idx_ext;
    logic [SW-1:0]           w_del_slot;
    logic [IW-1:0]           w_slot_ext;
    logic                    w_take_add;
    logic                    w_take_del;

    assign w_rdata    = t_entry'(w_rdata_raw);
    assign w_idx_ext  = IW'(i_cmd.idx);
    assign w_del_slot = w_idx_ext[SW-1:0];
    assign w_slot_ext = IW'(r_slot);
    assign w_take_del = !i_cmd_empty && (i_cmd.op == OP_DEL);
    assign w_take_add = !i_cmd_empty && (i_cmd.op == OP_ADD) && !i_res_full;

    // First-fit test on the slot whose entry is on the read port
    assign w_fit  = !r_busy[r_scan] && (!r_placed[r_scan] || (w_rdata.size >= r_len));
    assign w_last = (r_scan == SW'(SLOT_COUNT - 1));

    // Offset: kept if placed, else data start or end of the previous slot
    always_comb begin
        if (r_placed[r_scan]) begin
            w_sel_off = w_rdata.off;
        end else if (r_scan == '0) begin
            w_sel_off = OW'(i_data_start);
        end else begin
            w_sel_off = r_prev_end;
        end
    end

    // Page overflow check on the chosen slot
    assign w_sum      = (OW + 1)'(r_off) + (OW + 1)'(r_len);
    assign w_overflow = (w_sum >= (OW + 1)'(PAGE_BYTES));

    slotpg_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take_add) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_fit) begin
                    n_state = ST_CHECK;
                end else if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHECK: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd_pop          = 1'b0;
        o_res_push         = 1'b0;
        o_res.accepted     = 1'b0;
        o_res.granted_slot = '0;
        o_res.record_offset = '0;
        w_raddr            = '0;
        w_we               = 1'b0;
        w_wdata.off        = r_off;
        w_wdata.size       = r_len;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = w_take_add || w_take_del;
            end
            ST_SCAN: begin
                w_raddr = r_scan + 1'b1;
                if (!w_fit && w_last) begin
                    o_res_push = 1'b1;
                end
            end
            ST_CHECK: begin
                o_res_push = 1'b1;
                if (!w_overflow) begin
                    o_res.accepted      = 1'b1;
                    o_res.granted_slot  = w_slot_ext[IDX_W-1:0];
                    o_res.record_offset = r_off[OFS_W-1:0];
                    w_we                = !r_was_placed;
                end
            end
            default: ;
        endcase
    end

    // Slot flags and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= '0;
            r_placed <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && w_take_del && i_cmd.idx_ok) begin
                r_busy[w_del_slot] <= 1'b0;
            end
            if (r_state == ST_CHECK && !w_overflow) begin
                r_busy[r_slot]   <= 1'b1;
                r_placed[r_slot] <= 1'b1;
            end
        end
    end

    // Scan datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_take_add) begin
            r_len  <= i_cmd.len;
            r_scan <= '0;
        end
        if (r_state == ST_SCAN) begin
            r_prev_end <= w_rdata.off + OW'(w_rdata.size);
            if (w_fit) begin
                r_slot       <= r_scan;
                r_off        <= w_sel_off;
                r_was_placed <= r_placed[r_scan];
            end else begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* src/slotted_page_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Slot table allocator for one slotted page. Requests enter a two-entry
// command queue; add results leave through a two-entry result queue, so both
// sides stall independently. The back end handles one request at a time: a
// delete is done in the idle state, an add walks the slot table one slot per
// cycle through the slot RAM (registered read), then checks the granted slot
// for page overflow; an add ends rejected when no slot fits. Busy and placed
// flags are flip-flops cleared at reset, so there is no clearing pass. Each
// add yields one result (rejects report slot 0, offset 0); deletes yield none.
// Write data_start only while no request is in flight.
module slotted_page_slot_allocator #(
    parameter int PAGE_BYTES = 4096,
    parameter int SLOT_COUNT = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire                          i_kind,
    input  wire  [slotpg_pkg::LEN_W-1:0] i_record_length,
    input  wire  [slotpg_pkg::IDX_W-1:0] i_slot_index,
    output logic                         empty,
    input  wire                          pop,
    output logic                         o_accepted,
    output logic [slotpg_pkg::IDX_W-1:0] o_granted_slot,
    output logic [slotpg_pkg::OFS_W-1:0] o_record_offset,
    input  wire                          i_cfg_we,
    input  wire  [slotpg_pkg::CFG_W-1:0] i_cfg_wdata
);
    import slotpg_pkg::*;

    logic [CFG_W-1:0]           r_data_start;
    t_cmd                       w_cmd;
    logic                       w_cmd_empty;
    logic                       w_cmd_pop;
    logic                       w_res_full;
    logic                       w_res_push;
    t_result                    w_res_in;
    logic [$bits(t_result)-1:0] w_res_raw;
    t_result                    w_res_out;

    // Hold the record area start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= DATA_START_RST;
        end else if (i_cfg_we) begin
            r_data_start <= i_cfg_wdata;
        end
    end

    slotpg_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_record_length (i_record_length),
        .i_slot_index    (i_slot_index),
        .i_pop           (w_cmd_pop),
        .o_cmd           (w_cmd),
        .o_empty         (w_cmd_empty)
    );

    slotpg_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_empty  (w_cmd_empty),
        .o_cmd_pop    (w_cmd_pop),
        .i_data_start (r_data_start),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res        (w_res_in)
    );

    slotpg_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_raw),
        .o_empty (empty)
    );

    assign w_res_out       = t_result'(w_res_raw);
    assign o_accepted      = w_res_out.accepted;
    assign o_granted_slot  = w_res_out.granted_slot;
    assign o_record_offset = w_res_out.record_offset;

`ifndef SYNTHESIS
    // Space for a result is reserved when an add starts
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

    // The back end takes commands only when one is waiting
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command popped from empty queue");

    // A rejected add reports slot zero at offset zero
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && !w_res_in.accepted) |->
            (w_res_in.granted_slot == '0 && w_res_in.record_offset == '0))
        else $error("rejected add carries slot or offset");
`endif

endmodule
`default_nettype wire

/* bench/slotted_page_slot_allocator_chk.sv */
`timescale 1ns / 1ps
module slotted_page_slot_allocator_chk #(
    parameter int PAGE_BYTES = 4096,
    parameter int SLOT_COUNT = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  wire                          i_full,
    input  wire                          i_kind,
    input  wire  [slotpg_pkg::LEN_W-1:0] i_record_length,
    input  wire  [slotpg_pkg::IDX_W-1:0] i_slot_index,
    input  wire                          i_empty,
    input  wire                          i_pop,
    input  wire                          i_accepted,
    input  wire  [slotpg_pkg::IDX_W-1:0] i_granted_slot,
    input  wire  [slotpg_pkg::OFS_W-1:0] i_record_offset,
    input  wire                          i_cfg_we,
    input  wire  [slotpg_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                           o_pending,
    output int                           o_mismatches
);
    import slotpg_pkg::*;

    // Shadow copy of the page's slot table
    logic             slot_busy   [SLOT_COUNT];
    logic             slot_placed [SLOT_COUNT];
    logic [OFS_W-1:0] slot_ofs    [SLOT_COUNT];
    logic [LEN_W-1:0] slot_len    [SLOT_COUNT];
    logic [CFG_W-1:0] area_start;

    // Grants still owed by the block, oldest first
    t_result          grants_due [$];
    int               mismatch_cnt = 0;

    // First-fit placement of one record; updates the shadow table
    function automatic t_result place_record(input logic [LEN_W-1:0] len);
        t_result grant;
        int      pick;
        int      base;
        grant = '0;
        pick  = -1;
        // scan downward so the lowest fitting slot wins
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!slot_busy[s] && (!slot_placed[s] || slot_len[s] >= len)) pick = s;
        end
        if (pick < 0) return grant;

        // placed slots keep their spot; new ones follow the previous slot
        if (slot_placed[pick]) base = slot_ofs[pick];
        else if (pick == 0) base = area_start;
        else base = slot_ofs[pick-1] + slot_len[pick-1];

        // record would reach the page end: drop it, slot stays unplaced
        if (base + len >= PAGE_BYTES) begin
            slot_placed[pick] = 1'b0;
            return grant;
        end
        if (!slot_placed[pick]) begin
            slot_ofs[pick]    = base[OFS_W-1:0];
            slot_len[pick]    = len;
            slot_placed[pick] = 1'b1;
        end
        slot_busy[pick]     = 1'b1;
        grant.accepted      = 1'b1;
        grant.granted_slot  = pick[IDX_W-1:0];
        grant.record_offset = base[OFS_W-1:0];
        return grant;
    endfunction

    // Count one mismatch and print a line for each of the first 40
    task automatic report(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Watch both channels and the register port at each edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_busy[s]   = 1'b0;
                slot_placed[s] = 1'b0;
            end
            area_start = DATA_START_RST;
            grants_due.delete();
        end else begin
            // compare the item leaving first, it can never be one entering now
            if (i_pop && !i_empty) begin
                if (grants_due.size() == 0) begin
                    report("result with nothing pending, slot", i_granted_slot, -1);
                end else begin
                    want = grants_due.pop_front();
                    if (i_accepted !== want.accepted)
                        report("accepted", i_accepted, want.accepted);
                    if (i_granted_slot !== want.granted_slot)
                        report("granted_slot", i_granted_slot, want.granted_slot);
                    if (i_record_offset !== want.record_offset)
                        report("record_offset", i_record_offset, want.record_offset);
                end
            end
            if (i_push && !i_full) begin
                if (t_op'(i_kind) == OP_DEL) begin
                    // freeing a free slot changes nothing
                    if (int'(i_slot_index) < SLOT_COUNT) slot_busy[i_slot_index] = 1'b0;
                end else begin
                    grants_due.push_back(place_record(i_record_length));
                end
            end
            if (i_cfg_we) area_start = i_cfg_wdata;
        end
        o_pending    <= grants_due.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

/* bench/slotted_page_slot_allocator_tb.sv */
`timescale 1ns / 1ps
module slotted_page_slot_allocator_tb;
    import slotpg_pkg::*;

    localparam int PAGE_BYTES    = 4096;
    localparam int SLOT_COUNT    = 16;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 275;
    localparam int SETTLE_CYCLES = 3 * (SLOT_COUNT + 4);
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic             i_kind;
    logic [LEN_W-1:0] i_record_length;
    logic [IDX_W-1:0] i_slot_index;
    logic             empty;
    logic             pop;
    logic             o_accepted;
    logic [IDX_W-1:0] o_granted_slot;
    logic [OFS_W-1:0] o_record_offset;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    int               grants_pending;
    int               mismatches;
    bit               hold_req   = 1'b0;
    int               burst_left = 0;

    slotted_page_slot_allocator #(
        .PAGE_BYTES(PAGE_BYTES),
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_record_length(i_record_length),
        .i_slot_index   (i_slot_index),
        .empty          (empty),
        .pop            (pop),
        .o_accepted     (o_accepted),
        .o_granted_slot (o_granted_slot),
        .o_record_offset(o_record_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    slotted_page_slot_allocator_chk #(
        .PAGE_BYTES(PAGE_BYTES),
        .SLOT_COUNT(SLOT_COUNT)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_kind         (i_kind),
        .i_record_length(i_record_length),
        .i_slot_index   (i_slot_index),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_accepted     (o_accepted),
        .i_granted_slot (o_granted_slot),
        .i_record_offset(o_record_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_pending      (grants_pending),
        .o_mismatches   (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one item until it is taken, then pace bursts and gaps
    task automatic offer(input t_op kind, input logic [LEN_W-1:0] len,
                         input logic [IDX_W-1:0] idx);
        push            <= 1'b1;
        i_kind          <= kind;
        i_record_length <= len;
        i_slot_index    <= idx;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(0, 30);
        end
    endtask

    // Mostly small records so many slots get placed, some page-sized ones
    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return LEN_W'($urandom_range(0, 3));
        if (roll < 65) return LEN_W'($urandom_range(1, 160));
        if (roll < 88) return LEN_W'($urandom_range(1, 600));
        return LEN_W'($urandom_range(0, 4095));
    endfunction

    // Stop offering and wait until the block has nothing left in flight
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (grants_pending != 0) @(posedge i_clk);
        // deletes owe no result, so give the back end time to finish them
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_data_start(input logic [CFG_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        logic [CFG_W-1:0] sweep [PHASES];
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        i_kind          <= OP_ADD;
        i_record_length <= '0;
        i_slot_index    <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slot 0 would start at the last byte: every add overflows
        set_data_start(12'd4095);
        offer(OP_ADD, 12'd1, 4'd0);
        offer(OP_ADD, 12'd4095, 4'd15);
        offer(OP_DEL, 12'd0, 4'd0);
        offer(OP_DEL, 12'd4095, 4'd15);

        // record area from byte 0: placement, reuse, zero length, overflow
        set_data_start(12'd0);
        offer(OP_ADD, 12'd100, 4'd0);
        offer(OP_ADD, 12'd4095, 4'd0);
        offer(OP_ADD, 12'd0, 4'd0);
        offer(OP_ADD, 12'd2048, 4'd0);
        offer(OP_DEL, 12'd0, 4'd1);
        offer(OP_ADD, 12'd0, 4'd0);
        offer(OP_DEL, 12'd0, 4'd2);
        offer(OP_ADD, 12'd5, 4'd0);
        offer(OP_DEL, 12'd0, 4'd0);
        offer(OP_ADD, 12'd200, 4'd0);
        offer(OP_ADD, 12'd100, 4'd0);
        offer(OP_DEL, 12'd0, 4'd3);
        offer(OP_DEL, 12'd0, 4'd3);
        offer(OP_ADD, 12'd2730, 4'd0);

        // random phases, each under its own record area start
        sweep = '{12'd4095, 12'd0, CFG_W'($urandom_range(1, 4094)), 12'd96, 12'd2048,
                  CFG_W'($urandom_range(1, 4094))};
        for (int ph = 0; ph < PHASES; ph++) begin
            set_data_start(sweep[ph]);
            if (ph == 1) hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                offer(($urandom_range(0, 99) < 55) ? OP_ADD : OP_DEL, pick_length(),
                      IDX_W'($urandom_range(0, SLOT_COUNT - 1)));
            end
        end

        settle();
        @(negedge i_clk);
        if (mismatches == 0 && grants_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: stall on segments of random mode, one long hold-off
    initial begin
        int seg_len;
        int mode;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            seg_len = $urandom_range(10, 150);
            mode    = $urandom_range(0, 2);
            for (int n = 0; n < seg_len; n++) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    pop <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: begin
                        pop <= 1'b1;
                    end
                    1: begin
                        pop <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        pop <= ($urandom_range(0, 4) == 0);
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/slotpg_pkg.sv
src/slotpg_ram.sv
src/slotpg_fifo.sv
src/slotpg_front.sv
src/slotpg_back.sv
src/slotted_page_slot_allocator.sv
bench/slotted_page_slot_allocator_chk.sv
bench/slotted_page_slot_allocator_tb.sv
